// ===== hdl/rmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and constants for the register map table
// Command and status codes, config register indexes, the query broadcast to
// the cell rows and the search token that travels along them.
// ----------------------------------------------------------------------------
`default_nettype none

package rmt_pkg;

  // field widths
  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 32;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // table geometry
  localparam int DIG_ENTRIES_DEF = 64;
  localparam int ANA_ENTRIES_DEF = 64;
  localparam int DIG_ADDR_W = 15;
  localparam int DIG_VAL_W  = 8;
  localparam int ANA_ADDR_W = 16;
  localparam int ANA_VAL_W  = 16;

  // addresses below this go to the digital table
  localparam logic [ADDR_W-1:0] DIG_LIMIT = 16'd20000;
  localparam logic [DIG_VAL_W-1:0] DIG_ON  = 8'hFF;
  localparam logic [DIG_VAL_W-1:0] DIG_OFF = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_RD_WORD = 3'd1,
    CMD_WR_WORD = 3'd2,
    CMD_RD_PAIR = 3'd3,
    CMD_WR_PAIR = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_PRESENT = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD_ORDER = 1'b0,
    CFG_NOT_FOUND  = 1'b1
  } cfg_idx_t;

  // broadcast to every cell of one row
  typedef struct packed {
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic              sel0;
    logic              sel1;
    logic              add;
    logic              wr0;
    logic              wr1;
    logic [WORD_W-1:0] wv0;
    logic [WORD_W-1:0] wv1;
  } qry_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              found0;
    logic              found1;
    logic [WORD_W-1:0] val0;
    logic [WORD_W-1:0] val1;
  } tok_t;

  // digital entries hold all ones or all zeros
  function automatic logic [WORD_W-1:0] to_dig_word(input logic [WORD_W-1:0] word);
    return (word != '0) ? WORD_W'(DIG_ON) : WORD_W'(DIG_OFF);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rmt_req_if.sv =====
// ----------------------------------------------------------------------------
// rmt_req_if: command channel of the register map table
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmt_req_if;
  logic                        valid;
  logic                        ready;
  logic [rmt_pkg::CMD_W-1:0]   cmd;
  logic [rmt_pkg::ADDR_W-1:0]  reg_addr;
  logic [rmt_pkg::DATA_W-1:0]  wr_data;

  modport source (output valid, cmd, reg_addr, wr_data, input ready);
  modport sink   (input valid, cmd, reg_addr, wr_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rmt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rmt_rsp_if: response channel of the register map table
// Valid/ready channel carrying one status and read data beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rmt_pkg::STATUS_W-1:0] status;
  logic [rmt_pkg::DATA_W-1:0]   rd_data;

  modport source (output valid, status, rd_data, input ready);
  modport sink   (input valid, status, rd_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/register_map_table.sv =====
// ----------------------------------------------------------------------------
// register_map_table: sparse register map with digital and analog tables
// Adds, reads and writes words and 32-bit pairs; each table is a row of
// entry cells searched by a token moving one cell per cycle.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------
//  req      in   cmd, reg_addr, wr_data
//  rsp      out  status, rd_data
//  cfg      in   cfg_we, cfg_idx, cfg_data (write only)
//
//  An item is done only once the search token has crossed the longer
//  cell row, of max(DIG_ENTRIES, ANA_ENTRIES) cells, and the result forms.
//  One item is in work at a time; a finished result waits in the output
//  register while the next command is taken.
//  Table writes and adds commit in the cycle the result is loaded, so a
//  stalled rsp holds the block in its last step without side effects.
//  Reset empties both tables through their fill counts; no clearing pass.
//
`default_nettype none

module register_map_table #(
  parameter int DIG_ENTRIES = rmt_pkg::DIG_ENTRIES_DEF,
  parameter int ANA_ENTRIES = rmt_pkg::ANA_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rmt_req_if.sink                         req,
  rmt_rsp_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [rmt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rmt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rmt_pkg::*;

  localparam int SCAN_LEN = (DIG_ENTRIES > ANA_ENTRIES) ? DIG_ENTRIES : ANA_ENTRIES;
  localparam int SCAN_W   = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [SCAN_W-1:0]   scan_cnt;

  logic                word_order;
  logic [WORD_W-1:0]   not_found_word;

  cmd_t                cmd_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [DATA_W-1:0]   data_q;
  logic [ADDR_W-1:0]   addr_nxt;
  logic                is_dig0;
  logic                is_dig1;

  qry_t                dig_qry;
  qry_t                ana_qry;
  tok_t                dig_tok;
  tok_t                ana_tok;
  logic                dig_full;
  logic                ana_full;

  logic                found0;
  logic                found1;
  logic [WORD_W-1:0]   val0;
  logic [WORD_W-1:0]   val1;
  status_t             res_status;
  logic [DATA_W-1:0]   res_rd;
  logic                do_add;
  logic                do_wr0;
  logic                do_wr1;
  logic [WORD_W-1:0]   wv0;
  logic [WORD_W-1:0]   wv1;

  logic                accept;
  logic                load;
  logic                out_valid;
  status_t             out_status;
  logic [DATA_W-1:0]   out_rd;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_order     <= 1'b0;
      not_found_word <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_WORD_ORDER: word_order     <= cfg_data[0];
        CFG_NOT_FOUND:  not_found_word <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign req.ready = state == ST_IDLE;
  assign accept    = req.valid && req.ready;
  assign load      = (state == ST_DONE) && (!out_valid || rsp.ready);

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_t'(req.cmd);
      addr_q <= req.reg_addr;
      data_q <= req.wr_data;
    end
  end

  assign addr_nxt = addr_q + ADDR_W'(1);
  assign is_dig0  = addr_q < DIG_LIMIT;
  assign is_dig1  = addr_nxt < DIG_LIMIT;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (scan_cnt == SCAN_W'(SCAN_LEN - 1)) state_next = ST_DONE;
      ST_DONE: if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan_cnt <= '0;
      end else if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + SCAN_W'(1);
      end
    end
  end

  // result and update decisions from the collected tokens
  assign found0 = dig_tok.found0 | ana_tok.found0;
  assign found1 = dig_tok.found1 | ana_tok.found1;
  assign val0   = dig_tok.val0 | ana_tok.val0;
  assign val1   = dig_tok.val1 | ana_tok.val1;

  always_comb begin
    res_status = STAT_OK;
    res_rd     = '0;
    do_add     = 1'b0;
    do_wr0     = 1'b0;
    do_wr1     = 1'b0;
    wv0        = '0;
    wv1        = '0;
    unique case (cmd_q)
      CMD_ADD: begin
        if (found0) begin
          res_status = STAT_PRESENT;
        end else if (is_dig0 ? dig_full : ana_full) begin
          res_status = STAT_FULL;
        end else begin
          do_add = 1'b1;
        end
      end
      CMD_RD_WORD: begin
        if (found0) begin
          res_rd = DATA_W'(val0);
        end else begin
          res_status = STAT_MISS;
          res_rd     = DATA_W'(not_found_word);
        end
      end
      CMD_WR_WORD: begin
        if (found0) begin
          do_wr0 = 1'b1;
          wv0    = data_q[WORD_W-1:0];
        end else begin
          res_status = STAT_MISS;
        end
      end
      CMD_RD_PAIR: begin
        if (found0 && found1) begin
          res_rd = word_order ? {val1, val0} : {val0, val1};
        end else begin
          res_status = STAT_MISS;
        end
      end
      CMD_WR_PAIR: begin
        if (found0 && found1) begin
          do_wr0 = 1'b1;
          do_wr1 = 1'b1;
          wv0    = word_order ? data_q[WORD_W-1:0] : data_q[DATA_W-1:WORD_W];
          wv1    = word_order ? data_q[DATA_W-1:WORD_W] : data_q[WORD_W-1:0];
        end else begin
          res_status = STAT_MISS;
        end
      end
      default: ;
    endcase
  end

  // queries to the two rows; updates commit with the result load
  always_comb begin
    dig_qry.addr0 = addr_q;
    dig_qry.addr1 = addr_nxt;
    dig_qry.sel0  = is_dig0;
    dig_qry.sel1  = is_dig1;
    dig_qry.add   = load && do_add && is_dig0;
    dig_qry.wr0   = load && do_wr0;
    dig_qry.wr1   = load && do_wr1;
    dig_qry.wv0   = to_dig_word(wv0);
    dig_qry.wv1   = to_dig_word(wv1);

    ana_qry.addr0 = addr_q;
    ana_qry.addr1 = addr_nxt;
    ana_qry.sel0  = !is_dig0;
    ana_qry.sel1  = !is_dig1;
    ana_qry.add   = load && do_add && !is_dig0;
    ana_qry.wr0   = load && do_wr0;
    ana_qry.wr1   = load && do_wr1;
    ana_qry.wv0   = wv0;
    ana_qry.wv1   = wv1;
  end

  rmt_chain #(
    .ENTRIES (DIG_ENTRIES),
    .ADDR_W  (DIG_ADDR_W),
    .VAL_W   (DIG_VAL_W)
  ) u_dig (
    .clk     (clk),
    .rst     (rst),
    .qry     (dig_qry),
    .tok_out (dig_tok),
    .full    (dig_full)
  );

  rmt_chain #(
    .ENTRIES (ANA_ENTRIES),
    .ADDR_W  (ANA_ADDR_W),
    .VAL_W   (ANA_VAL_W)
  ) u_ana (
    .clk     (clk),
    .rst     (rst),
    .qry     (ana_qry),
    .tok_out (ana_tok),
    .full    (ana_full)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res_status;
      out_rd     <= res_rd;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.rd_data = out_rd;

  // checks
  a_add_one_row: assert property (@(posedge clk) disable iff (rst)
    !(dig_qry.add && ana_qry.add))
    else $error("add issued to both tables");

  a_second_write_pair_only: assert property (@(posedge clk) disable iff (rst)
    dig_qry.wr1 |-> cmd_q == CMD_WR_PAIR)
    else $error("second word written by a non-pair command");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && !req.ready)
    else $error("accepted command did not start a scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_DONE)
    else $error("result appeared outside the final step");

endmodule

`default_nettype wire

// ===== hdl/rmt_cell.sv =====
// ----------------------------------------------------------------------------
// rmt_cell: one table entry
// Holds an address and a value, matches both query addresses against its
// entry and merges any hit into the search token passed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_cell #(
  parameter int ADDR_W = 16,
  parameter int VAL_W  = 16,
  parameter int IDX    = 0,
  parameter int CNT_W  = 7
) (
  input  logic                 clk,
  input  rmt_pkg::qry_t        qry,
  input  logic [CNT_W-1:0]     cnt,
  input  rmt_pkg::tok_t        tin,
  output rmt_pkg::tok_t        tout
);
  import rmt_pkg::*;

  logic [ADDR_W-1:0] entry_addr;
  logic [VAL_W-1:0]  entry_val;
  tok_t              tok;
  logic              filled;
  logic              slot;
  logic              hit0;
  logic              hit1;
  logic [WORD_W-1:0] val_word;

  // entry is live below the fill count; next free slot sits at the count
  assign filled   = CNT_W'(IDX) < cnt;
  assign slot     = cnt == CNT_W'(IDX);
  assign hit0     = filled && qry.sel0 && (entry_addr == qry.addr0[ADDR_W-1:0]);
  assign hit1     = filled && qry.sel1 && (entry_addr == qry.addr1[ADDR_W-1:0]);
  assign val_word = WORD_W'(entry_val);

  // entry update: add claims the slot, writes land on hits
  always_ff @(posedge clk) begin
    if (qry.add && slot) begin
      entry_addr <= qry.addr0[ADDR_W-1:0];
      entry_val  <= '0;
    end else if (qry.wr0 && hit0) begin
      entry_val <= qry.wv0[VAL_W-1:0];
    end else if (qry.wr1 && hit1) begin
      entry_val <= qry.wv1[VAL_W-1:0];
    end
  end

  // merge this entry into the token
  always_ff @(posedge clk) begin
    tok.found0 <= tin.found0 | hit0;
    tok.found1 <= tin.found1 | hit1;
    tok.val0   <= tin.val0 | (hit0 ? val_word : '0);
    tok.val1   <= tin.val1 | (hit1 ? val_word : '0);
  end

  assign tout = tok;

endmodule

`default_nettype wire

// ===== hdl/rmt_chain.sv =====
// ----------------------------------------------------------------------------
// rmt_chain: one table as a row of entry cells
// Keeps the fill count, broadcasts the query and collects the search token
// at the end of the row, one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_chain #(
  parameter int ENTRIES = 64,
  parameter int ADDR_W  = 16,
  parameter int VAL_W   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  rmt_pkg::qry_t qry,
  output rmt_pkg::tok_t tok_out,
  output logic          full
);
  import rmt_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [CNT_W-1:0] cnt;
  tok_t             tok [0:ENTRIES];

  assign full = cnt == CNT_W'(ENTRIES);

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (qry.add && !full) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // empty token enters the row
  assign tok[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rmt_cell #(
      .ADDR_W (ADDR_W),
      .VAL_W  (VAL_W),
      .IDX    (i),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk  (clk),
      .qry  (qry),
      .cnt  (cnt),
      .tin  (tok[i]),
      .tout (tok[i+1])
    );
  end

  assign tok_out = tok[ENTRIES];

endmodule

`default_nettype wire

// ===== verif/tb_register_map_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_map_table: self-checking bench for the register map table
// Drives add, word, pair and unused commands through the req channel with random
// gaps, predicts every response with a local copy of both tables and the
// config, and checks each rsp beat field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_register_map_table;
  import rmt_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 11;
  localparam int DIG_N       = DIG_ENTRIES_DEF;
  localparam int ANA_N       = ANA_ENTRIES_DEF;
  localparam int RAND_PHASE  = 290;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP   = 60;
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cmd_beat_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] rd_data;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rmt_req_if req_ch ();
  rmt_rsp_if rsp_ch ();

  register_map_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // bench state
  cmd_beat_t cmd_pending_q[$];
  rsp_beat_t awaited_rsp_q[$];
  logic [ADDR_W-1:0] dig_pool[$];
  logic [ADDR_W-1:0] ana_pool[$];
  int issued_cnt = 0;
  int checked_cnt = 0;
  int err_count = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_go = 1'b0;
  logic rx_hold;

  // shadow of the map contents and config
  logic [ADDR_W-1:0]    dig_addr_m [DIG_N];
  logic [DIG_VAL_W-1:0] dig_val_m  [DIG_N];
  int                   dig_fill = 0;
  logic [ADDR_W-1:0]    ana_addr_m [ANA_N];
  logic [ANA_VAL_W-1:0] ana_val_m  [ANA_N];
  int                   ana_fill = 0;
  logic                 word_order_m = 1'b0;
  logic [WORD_W-1:0]    miss_word_m = '0;

  always #(CLK_HALF) clk = ~clk;

  // linear search in the table that owns the address, -1 on a miss
  function automatic int find_slot(logic [ADDR_W-1:0] addr);
    if (addr < DIG_LIMIT) begin
      for (int i = 0; i < dig_fill; i++)
        if (dig_addr_m[i] == addr) return i;
    end else begin
      for (int i = 0; i < ana_fill; i++)
        if (ana_addr_m[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic logic [WORD_W-1:0] read_slot(logic [ADDR_W-1:0] addr, int idx);
    if (addr < DIG_LIMIT) return {8'h00, dig_val_m[idx]};
    return ana_val_m[idx];
  endfunction

  // digital entries collapse any nonzero word to all ones
  function automatic void write_slot(logic [ADDR_W-1:0] addr, int idx,
                                     logic [WORD_W-1:0] word);
    if (addr < DIG_LIMIT) dig_val_m[idx] = (word != '0) ? DIG_ON : DIG_OFF;
    else ana_val_m[idx] = word;
  endfunction

  function automatic status_t add_slot(logic [ADDR_W-1:0] addr);
    if (find_slot(addr) >= 0) return STAT_PRESENT;
    if (addr < DIG_LIMIT) begin
      if (dig_fill >= DIG_N) return STAT_FULL;
      dig_addr_m[dig_fill] = addr;
      dig_val_m[dig_fill] = DIG_OFF;
      dig_fill++;
    end else begin
      if (ana_fill >= ANA_N) return STAT_FULL;
      ana_addr_m[ana_fill] = addr;
      ana_val_m[ana_fill] = '0;
      ana_fill++;
    end
    return STAT_OK;
  endfunction

  // response of the map to one command, updating the shadow tables
  function automatic rsp_beat_t map_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                           logic [DATA_W-1:0] data);
    rsp_beat_t r;
    logic [ADDR_W-1:0] nxt_addr;
    logic [WORD_W-1:0] w0, w1;
    int s0, s1;
    r.status = STAT_OK;
    r.rd_data = '0;
    nxt_addr = addr + 16'd1;
    case (cmd) inside
      CMD_ADD: r.status = add_slot(addr);
      CMD_RD_WORD: begin
        s0 = find_slot(addr);
        if (s0 >= 0) begin
          r.rd_data = {16'd0, read_slot(addr, s0)};
        end else begin
          r.status = STAT_MISS;
          r.rd_data = {16'd0, miss_word_m};
        end
      end
      CMD_WR_WORD: begin
        s0 = find_slot(addr);
        if (s0 >= 0) write_slot(addr, s0, data[15:0]);
        else r.status = STAT_MISS;
      end
      CMD_RD_PAIR, CMD_WR_PAIR: begin
        s0 = find_slot(addr);
        s1 = find_slot(nxt_addr);
        if (s0 < 0 || s1 < 0) begin
          r.status = STAT_MISS;
        end else if (cmd == CMD_RD_PAIR) begin
          w0 = read_slot(addr, s0);
          w1 = read_slot(nxt_addr, s1);
          r.rd_data = word_order_m ? {w1, w0} : {w0, w1};
        end else begin
          write_slot(addr, s0, word_order_m ? data[15:0] : data[31:16]);
          write_slot(nxt_addr, s1, word_order_m ? data[31:16] : data[15:0]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (err_count < PRINT_CAP)
      $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    cmd_beat_t b;
    b.cmd = cmd;
    b.addr = addr;
    b.data = data;
    cmd_pending_q.push_back(b);
  endtask

  // mostly pooled addresses so adds, hits and pairs happen; a few wild beats
  function automatic cmd_beat_t random_cmd();
    cmd_beat_t b;
    int roll;
    roll = $urandom_range(99);
    b.data = $urandom();
    if ($urandom_range(3) == 0) b.data[15:0] = '0;
    if (roll < 5) begin
      b.cmd = 3'($urandom_range(7));
      b.addr = 16'($urandom_range(65535));
      return b;
    end
    if ($urandom_range(1) == 1) b.addr = dig_pool[$urandom_range(dig_pool.size() - 1)];
    else b.addr = ana_pool[$urandom_range(ana_pool.size() - 1)];
    if (roll < 30) b.cmd = CMD_ADD;
    else if (roll < 52) b.cmd = CMD_RD_WORD;
    else if (roll < 70) b.cmd = CMD_WR_WORD;
    else if (roll < 83) b.cmd = CMD_RD_PAIR;
    else if (roll < 96) b.cmd = CMD_WR_PAIR;
    else b.cmd = CMD_UNUSED_FIRST + 3'($urandom_range(2));
    return b;
  endfunction

  // both registers, only while nothing is in flight
  task automatic write_cfg(input logic order, input logic [WORD_W-1:0] miss_word);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WORD_ORDER;
    cfg_data <= {15'd0, order};
    @(posedge clk);
    cfg_idx <= CFG_NOT_FOUND;
    cfg_data <= miss_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    word_order_m = order;
    miss_word_m = miss_word;
  endtask

  task automatic drain();
    while (cmd_pending_q.size() != 0 || issued_cnt != checked_cnt) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) cmd_pending_q.push_back(random_cmd());
  endtask

  // req driver: predicts on acceptance, then offers the next pending beat
  always @(posedge clk) begin : cmd_driver
    cmd_beat_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_ADD;
      req_ch.reg_addr <= '0;
      req_ch.wr_data <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        awaited_rsp_q.push_back(map_access(req_ch.cmd, req_ch.reg_addr, req_ch.wr_data));
      if (!req_ch.valid || req_ch.ready) begin
        if (cmd_pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = cmd_pending_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= nxt.cmd;
          req_ch.reg_addr <= nxt.addr;
          req_ch.wr_data <= nxt.data;
          issued_cnt++;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // rsp monitor: compares each beat with the oldest awaited response
  always @(posedge clk) begin : rsp_monitor
    rsp_beat_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch("unexpected rsp beat, status/rd_data", {30'd0, rsp_ch.status},
                          rsp_ch.rd_data);
        end else begin
          want = awaited_rsp_q.pop_front();
          checked_cnt++;
          if (rsp_ch.status !== want.status)
            report_mismatch("status", {30'd0, rsp_ch.status}, {30'd0, want.status});
          if (rsp_ch.rd_data !== want.rd_data)
            report_mismatch("rd_data", rsp_ch.rd_data, want.rd_data);
        end
      end
      rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up into the req channel
  initial begin : rx_long_hold
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] base;
    cfg_we = 1'b0;
    cfg_idx = CFG_WORD_ORDER;
    cfg_data = '0;

    // address pools made of adjacent pairs, table boundaries included
    dig_pool = '{16'd0, 16'd1, 16'd19998, 16'd19999};
    ana_pool = '{16'd20000, 16'd20001, 16'd65534, 16'd65535};
    for (int i = 0; i < 40; i++) begin
      base = 16'($urandom_range(19997, 2));
      dig_pool.push_back(base);
      dig_pool.push_back(base + 16'd1);
      base = 16'($urandom_range(65533, 20002));
      ana_pool.push_back(base);
      ana_pool.push_back(base + 16'd1);
    end

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: sender 7, receiver 65 idle per hundred
    tx_idle_pct = 7;
    rx_idle_pct = 65;
    write_cfg(1'b0, 16'h0000);
    queue_cmd(CMD_RD_WORD, 16'd0, 32'h0);
    queue_cmd(CMD_ADD, 16'd0, 32'h0);
    queue_cmd(CMD_ADD, 16'd0, 32'hFFFFFFFF);
    queue_cmd(CMD_RD_WORD, 16'd0, 32'h0);
    queue_cmd(CMD_WR_WORD, 16'd0, 32'hFFFF0000);
    queue_cmd(CMD_RD_WORD, 16'd0, 32'h0);
    queue_cmd(CMD_WR_WORD, 16'd0, 32'h00000001);
    queue_cmd(CMD_RD_WORD, 16'd0, 32'h0);
    queue_cmd(CMD_ADD, 16'd65535, 32'h0);
    queue_cmd(CMD_WR_PAIR, 16'd65535, 32'hABCD0000);
    queue_cmd(CMD_RD_PAIR, 16'd65535, 32'h0);
    queue_cmd(CMD_RD_WORD, 16'd65535, 32'h0);
    queue_cmd(CMD_ADD, 16'd19999, 32'h0);
    queue_cmd(CMD_ADD, 16'd20000, 32'h0);
    queue_cmd(CMD_WR_PAIR, 16'd19999, 32'hFFFFFFFF);
    queue_cmd(CMD_RD_PAIR, 16'd19999, 32'h0);
    queue_cmd(CMD_RD_PAIR, 16'd20000, 32'h0);
    queue_cmd(CMD_WR_PAIR, 16'd20000, 32'h12345678);
    queue_cmd(CMD_WR_WORD, 16'd30000, 32'h0000BEEF);
    queue_cmd(CMD_RD_WORD, 16'd30000, 32'h0);
    queue_cmd(CMD_UNUSED_FIRST, 16'd0, 32'hFFFFFFFF);
    queue_cmd(CMD_UNUSED_FIRST + 3'd1, 16'd65535, 32'hFFFFFFFF);
    queue_cmd(CMD_UNUSED_FIRST + 3'd2, 16'd20000, 32'h0);
    drain();

    // random with a long receiver stall while the sender keeps offering
    write_cfg(1'b1, 16'hFFFF);
    run_random(RAND_PHASE);
    hold_go = 1'b1;
    drain();
    write_cfg(1'b0, 16'($urandom_range(65535)));
    run_random(RAND_PHASE);
    drain();

    // sender 65, receiver 7 idle per hundred
    tx_idle_pct = 65;
    rx_idle_pct = 7;
    write_cfg(1'b1, 16'($urandom_range(65535)));
    run_random(RAND_PHASE);
    drain();
    write_cfg(1'b0, 16'hFFFF);
    run_random(RAND_PHASE);
    drain();

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_cfg(1'b1, 16'h0000);
    run_random(RAND_PHASE);
    drain();
    write_cfg(1'($urandom_range(1)), 16'($urandom_range(65535)));
    run_random(RAND_PHASE);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_rsp_q.size() != 0)
      report_mismatch("responses never arrived", 32'(awaited_rsp_q.size()), 32'd0);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
